// ----- rtl/assert_macros.svh -----
// Assertion helpers for the sample playback voice.
// Each use expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPV_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define SPV_NEVER(name, cond, msg) \
	`SPV_ASSERT(name, !(cond), msg)

`endif

// ----- rtl/spv_pkg.sv -----
package spv_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

	typedef logic [ADDR_BITS-1:0]          addr_t;
	typedef logic signed [SAMPLE_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_TRIGGER = 2'd1,
		ACT_TICK    = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_POINT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEREO_SOURCE = 3'd5;

	localparam logic [19:0] PHASE_STEP_RESET = 20'h10000;
	localparam logic [15:0] LEVEL_RESET      = 16'h4000;

	// velocity * level + 63 fits 23 bits; the divide by 127 is a multiply
	// by ceil(2^30 / 127), exact for every value below 2^23.
	localparam int            VL_W        = 23;
	localparam logic [VL_W-1:0] VEL_BIAS  = 23'd63;
	localparam int            RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP_127 = 24'd8454661;
	localparam int            RECIP_SHIFT = 30;
	localparam int            GAIN_PROD_W = VL_W + RECIP_W;

	// word (SAMPLE_BITS s) * gain (Q2.14) * pan gain (Q1.15), rounded by 2^29.
	localparam int GAIN_S_W    = 17;
	localparam int P1_W        = SAMPLE_BITS + GAIN_S_W;
	localparam int P2_W        = P1_W + GAIN_S_W;
	localparam int SCALE_SHIFT = 29;
	localparam int CONTRIB_W   = P2_W - SCALE_SHIFT;
	localparam int SUM_W       = CONTRIB_W + 1;

	localparam logic signed [GAIN_S_W-1:0] Q15_ONE   = 17'sd32768;
	localparam logic signed [P2_W-1:0]     ROUND_ADD = P2_W'(64'sd1 <<< (SCALE_SHIFT - 1));

	localparam logic signed [SUM_W-1:0] WORD_MAX = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] WORD_MIN = SUM_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	typedef struct packed {
		logic capture;
		logic mem_we;
		logic gain_mul;
		logic gain_ld;
		logic tick_go;
		logic scale1;
		logic scale2;
		logic stop;
		logic res_ld;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    playing;
		logic    at_end;
	} sts_t;

	function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
		word_t r;
		if (v > WORD_MAX) begin
			r = word_t'(WORD_MAX);
		end else if (v < WORD_MIN) begin
			r = word_t'(WORD_MIN);
		end else begin
			r = word_t'(v);
		end
		return r;
	endfunction

endpackage

// ----- rtl/spv_ctrl.sv -----
`include "assert_macros.svh"

module spv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  spv_pkg::sts_t     sts,
	output spv_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_MUL1   = 5'b00100,
		ST_MUL2   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.action)
					spv_pkg::ACT_LOAD: begin
						cmd.mem_we = 1'b1;
						state_d    = ST_FINISH;
					end
					spv_pkg::ACT_TRIGGER: begin
						cmd.gain_mul = 1'b1;
						state_d      = ST_MUL1;
					end
					spv_pkg::ACT_STOP: begin
						cmd.stop = 1'b1;
						state_d  = ST_FINISH;
					end
					spv_pkg::ACT_TICK: begin
						if (!sts.playing) begin
							state_d = ST_FINISH;
						end else if (sts.at_end) begin
							cmd.stop = 1'b1;
							state_d  = ST_FINISH;
						end else begin
							cmd.tick_go = 1'b1;
							state_d     = ST_MUL1;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_MUL1: begin
				if (sts.action == spv_pkg::ACT_TRIGGER) begin
					cmd.gain_ld = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					cmd.scale1 = 1'b1;
					state_d    = ST_MUL2;
				end
			end
			ST_MUL2: begin
				cmd.scale2 = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.res_ld) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	`SPV_ASSERT(a_accept_exec, (in_valid && !in_stall) |=> (state_q == ST_EXEC), "accepted transaction did not enter execution")
	`SPV_ASSERT(a_rose_finish, $rose(out_valid) |-> $past(state_q == ST_FINISH), "result appeared outside finish")
	`SPV_ASSERT(a_hold_result, (state_q == ST_FINISH && out_valid && out_stall) |=> (state_q == ST_FINISH && out_valid), "stalled result overwritten")
	`SPV_ASSERT(a_mul2_order, (state_q == ST_MUL2) |-> $past(state_q == ST_MUL1), "second multiply without first")

endmodule

// ----- rtl/spv_datapath.sv -----
module spv_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spv_pkg::cmd_t                       cmd,
	output spv_pkg::sts_t                       sts,
	input  logic                                cfg_we,
	input  logic [spv_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [spv_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [1:0]                          action,
	input  logic [15:0]                         address,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] sample_left,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] sample_right,
	input  logic [6:0]                          velocity,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] mix_left,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] mix_right,
	output logic signed [spv_pkg::SAMPLE_BITS-1:0] out_left,
	output logic signed [spv_pkg::SAMPLE_BITS-1:0] out_right,
	output logic                                voice_active
);

	spv_pkg::word_t left_mem  [spv_pkg::STORE_DEPTH];
	spv_pkg::word_t right_mem [spv_pkg::STORE_DEPTH];

	logic [15:0] start_offset_q;
	logic [16:0] end_point_q;
	logic [19:0] phase_step_q;
	logic [15:0] level_q;
	logic signed [15:0] pan_q;
	logic        stereo_q;

	logic [31:0] playhead_q;
	logic        playing_q;
	logic [15:0] gain_q;
	logic        mix_en_q;

	spv_pkg::action_t action_q;
	logic [15:0]      address_q;
	spv_pkg::word_t   sample_left_q, sample_right_q, mix_left_q, mix_right_q;
	logic [6:0]       velocity_q;
	spv_pkg::word_t   rdl_q, rdr_q;

	logic [spv_pkg::VL_W-1:0]              vl_s1;
	logic signed [spv_pkg::P1_W-1:0]       p1l_s1, p1r_s1;
	logic signed [spv_pkg::P2_W-1:0]       p2l_s2, p2r_s2;

	spv_pkg::word_t out_left_q, out_right_q;
	logic           out_active_q;

	logic [15:0]                               idx;
	logic [16:0]                               end_eff;
	spv_pkg::addr_t                            raddr, waddr;
	spv_pkg::word_t                            wr_sel;
	logic signed [spv_pkg::GAIN_S_W-1:0]       gain_s, pan_ext, gl, gr;
	logic [32:0]                               next_head;
	logic [spv_pkg::GAIN_PROD_W-1:0]           gain_prod;
	logic signed [spv_pkg::P2_W-1:0]           rnd_l, rnd_r;
	logic signed [spv_pkg::SUM_W-1:0]          sum_l, sum_r;

	assign idx     = playhead_q[31:16];
	assign end_eff = (end_point_q > {1'b0, start_offset_q}) ? end_point_q : {1'b0, start_offset_q};
	assign raddr   = spv_pkg::addr_t'(idx);
	assign waddr   = spv_pkg::addr_t'(address_q);
	assign wr_sel  = stereo_q ? rdr_q : rdl_q;
	assign gain_s  = {1'b0, gain_q};
	assign pan_ext = {pan_q[15], pan_q};
	assign gl      = (pan_q > 16'sd0) ? spv_pkg::Q15_ONE - pan_ext : spv_pkg::Q15_ONE;
	assign gr      = (pan_q < 16'sd0) ? spv_pkg::Q15_ONE + pan_ext : spv_pkg::Q15_ONE;
	assign next_head = {1'b0, playhead_q} + 33'(phase_step_q);
	assign gain_prod = spv_pkg::GAIN_PROD_W'(vl_s1) * spv_pkg::GAIN_PROD_W'(spv_pkg::RECIP_127);

	assign rnd_l = p2l_s2 + spv_pkg::ROUND_ADD;
	assign rnd_r = p2r_s2 + spv_pkg::ROUND_ADD;

	always_comb begin
		sum_l = spv_pkg::SUM_W'(mix_left_q);
		sum_r = spv_pkg::SUM_W'(mix_right_q);
		if (mix_en_q) begin
			sum_l = sum_l + spv_pkg::SUM_W'($signed(rnd_l[spv_pkg::P2_W-1:spv_pkg::SCALE_SHIFT]));
			sum_r = sum_r + spv_pkg::SUM_W'($signed(rnd_r[spv_pkg::P2_W-1:spv_pkg::SCALE_SHIFT]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q <= '0;
			end_point_q    <= '0;
			phase_step_q   <= spv_pkg::PHASE_STEP_RESET;
			level_q        <= spv_pkg::LEVEL_RESET;
			pan_q          <= '0;
			stereo_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				spv_pkg::CFG_START_OFFSET:  start_offset_q <= cfg_wdata[15:0];
				spv_pkg::CFG_END_POINT:     end_point_q    <= cfg_wdata[16:0];
				spv_pkg::CFG_PHASE_STEP:    phase_step_q   <= cfg_wdata[19:0];
				spv_pkg::CFG_LEVEL:         level_q        <= cfg_wdata[15:0];
				spv_pkg::CFG_PAN:           pan_q          <= cfg_wdata[15:0];
				spv_pkg::CFG_STEREO_SOURCE: stereo_q       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playhead_q <= '0;
			playing_q  <= 1'b0;
			gain_q     <= '0;
			mix_en_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				mix_en_q <= 1'b0;
			end
			if (cmd.tick_go) begin
				mix_en_q <= 1'b1;
			end
			if (cmd.gain_ld) begin
				gain_q     <= gain_prod[spv_pkg::RECIP_SHIFT+15:spv_pkg::RECIP_SHIFT];
				playhead_q <= {start_offset_q, 16'h0000};
				playing_q  <= 1'b1;
			end
			if (cmd.stop) begin
				playhead_q <= '0;
				playing_q  <= 1'b0;
			end
			if (cmd.scale1) begin
				if (next_head[32]) begin
					playhead_q <= '0;
					playing_q  <= 1'b0;
				end else begin
					playhead_q <= next_head[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q       <= spv_pkg::action_t'(action);
			address_q      <= address;
			sample_left_q  <= sample_left;
			sample_right_q <= sample_right;
			velocity_q     <= velocity;
			mix_left_q     <= mix_left;
			mix_right_q    <= mix_right;
		end
		if (cmd.gain_mul) begin
			vl_s1 <= spv_pkg::VL_W'(velocity_q) * spv_pkg::VL_W'(level_q) + spv_pkg::VEL_BIAS;
		end
		if (cmd.scale1) begin
			p1l_s1 <= spv_pkg::P1_W'(rdl_q) * spv_pkg::P1_W'(gain_s);
			p1r_s1 <= spv_pkg::P1_W'(wr_sel) * spv_pkg::P1_W'(gain_s);
		end
		if (cmd.scale2) begin
			p2l_s2 <= spv_pkg::P2_W'(p1l_s1) * spv_pkg::P2_W'(gl);
			p2r_s2 <= spv_pkg::P2_W'(p1r_s1) * spv_pkg::P2_W'(gr);
		end
		if (cmd.res_ld) begin
			if (action_q == spv_pkg::ACT_TICK) begin
				out_left_q  <= spv_pkg::sat_word(sum_l);
				out_right_q <= spv_pkg::sat_word(sum_r);
			end else begin
				out_left_q  <= '0;
				out_right_q <= '0;
			end
			out_active_q <= playing_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			left_mem[waddr]  <= sample_left_q;
			right_mem[waddr] <= sample_right_q;
		end
		rdl_q <= left_mem[raddr];
		rdr_q <= right_mem[raddr];
	end

	assign sts.action  = action_q;
	assign sts.playing = playing_q;
	assign sts.at_end  = ({1'b0, idx} >= end_eff);

	assign out_left     = out_left_q;
	assign out_right    = out_right_q;
	assign voice_active = out_active_q;

endmodule

// ----- rtl/sample_playback_voice.sv -----
// One playback voice of a drum sampler.
// Input channel (in_valid / in_stall) carries one action per transaction:
// load a stereo sample word, trigger, tick or stop. Every transaction yields
// exactly one result on the output channel (out_valid / out_stall):
// out_left / out_right hold the mixed and saturated audio for a tick and
// zero otherwise; voice_active reports whether the voice still plays.
// From input acceptance to a valid result, load and stop and a tick that
// finds the voice idle or at its end point pass the EXEC and FINISH states;
// a trigger passes EXEC, MUL1 and FINISH (gain multiply and reciprocal
// divide); a playing tick passes EXEC, MUL1, MUL2 and FINISH (sample store
// read, then two multiply stages per side). A new transaction is taken
// only once the previous result is registered and the controller is idle.
// When the receiver stalls, the result is held in the output register; the
// next transaction is still accepted and computed, then waits in its last
// step until the held result is taken.
// Reset clears the playhead, playing flag, voice gain and config registers
// (phase step and level to defaults). The sample stores are not cleared:
// read only entries that have been loaded. Configuration writes (cfg_we,
// cfg_idx, cfg_wdata) take effect at once and belong in idle periods.
module sample_playback_voice (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [spv_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [spv_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             action,
	input  logic [15:0]                            address,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] sample_left,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] sample_right,
	input  logic [6:0]                             velocity,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] mix_left,
	input  logic signed [spv_pkg::SAMPLE_BITS-1:0] mix_right,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [spv_pkg::SAMPLE_BITS-1:0] out_left,
	output logic signed [spv_pkg::SAMPLE_BITS-1:0] out_right,
	output logic                                   voice_active
);

	spv_pkg::cmd_t cmd;
	spv_pkg::sts_t sts;

	spv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spv_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.action       (action),
		.address      (address),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.velocity     (velocity),
		.mix_left     (mix_left),
		.mix_right    (mix_right),
		.out_left     (out_left),
		.out_right    (out_right),
		.voice_active (voice_active)
	);

endmodule

// ----- tb/sv/voice_checker.sv -----
`timescale 1ns / 100ps
module voice_checker import spv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [15:0]           address,
	input  word_t                 sample_left,
	input  word_t                 sample_right,
	input  logic [6:0]            velocity,
	input  word_t                 mix_left,
	input  word_t                 mix_right,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  word_t                 out_left,
	input  word_t                 out_right,
	input  logic                  voice_active,
	output int                    errors,
	output int                    outstanding
);

	typedef struct packed {
		word_t left;
		word_t right;
		logic  active;
	} frame_t;

	word_t              left_mem [STORE_DEPTH];
	word_t              right_mem [STORE_DEPTH];
	logic [31:0]        head;
	logic               playing;
	logic [15:0]        gain;
	logic [15:0]        start_reg;
	logic [16:0]        end_reg;
	logic [19:0]        step_reg;
	logic [15:0]        level_reg;
	logic signed [15:0] pan_reg;
	logic               stereo_reg;
	frame_t             due_frames [$];

	function automatic word_t clamp_word(longint v);
		longint lim;
		lim = longint'(1) <<< (SAMPLE_BITS - 1);
		if (v > lim - 1) begin
			return word_t'(lim - 1);
		end
		if (v < -lim) begin
			return word_t'(-lim);
		end
		return word_t'(v);
	endfunction

	function automatic longint scaled(word_t w, longint pan_gain);
		longint p;
		p = longint'(w) * longint'(gain) * pan_gain;
		return (p + (longint'(1) <<< 28)) >>> 29;
	endfunction

	function automatic frame_t play_step(action_t act, logic [15:0] addr, word_t sl, word_t sr,
			logic [6:0] vel, word_t ml, word_t mr);
		frame_t      f;
		longint      acc_l;
		longint      acc_r;
		longint      gl;
		longint      gr;
		logic [15:0] idx;
		logic [16:0] stop_at;
		logic [32:0] nxt;
		word_t       wl;
		word_t       wr;
		f = '0;
		case (act)
			ACT_LOAD: begin
				left_mem[addr] = sl;
				right_mem[addr] = sr;
			end
			ACT_TRIGGER: begin
				gain = 16'((int'(vel) * int'(level_reg) + 63) / 127);
				head = {start_reg, 16'h0000};
				playing = 1'b1;
			end
			ACT_STOP: begin
				playing = 1'b0;
				head = '0;
			end
			ACT_TICK: begin
				acc_l = ml;
				acc_r = mr;
				if (playing) begin
					idx = head[31:16];
					stop_at = (end_reg > {1'b0, start_reg}) ? end_reg : {1'b0, start_reg};
					if ({1'b0, idx} >= stop_at) begin
						playing = 1'b0;
						head = '0;
					end else begin
						gl = (pan_reg > 0) ? 32768 - longint'(pan_reg) : 32768;
						gr = (pan_reg < 0) ? 32768 + longint'(pan_reg) : 32768;
						wl = left_mem[idx];
						wr = stereo_reg ? right_mem[idx] : wl;
						acc_l += scaled(wl, gl);
						acc_r += scaled(wr, gr);
						nxt = {1'b0, head} + {13'b0, step_reg};
						if (nxt[32]) begin
							playing = 1'b0;
							head = '0;
						end else begin
							head = nxt[31:0];
						end
					end
				end
				f.left = clamp_word(acc_l);
				f.right = clamp_word(acc_r);
			end
			default: ;
		endcase
		f.active = playing;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			head = '0;
			playing = 1'b0;
			gain = '0;
			start_reg = '0;
			end_reg = '0;
			step_reg = PHASE_STEP_RESET;
			level_reg = LEVEL_RESET;
			pan_reg = '0;
			stereo_reg = 1'b0;
			due_frames.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_START_OFFSET:  start_reg = cfg_wdata[15:0];
					CFG_END_POINT:     end_reg = cfg_wdata[16:0];
					CFG_PHASE_STEP:    step_reg = cfg_wdata[19:0];
					CFG_LEVEL:         level_reg = cfg_wdata[15:0];
					CFG_PAN:           pan_reg = cfg_wdata[15:0];
					CFG_STEREO_SOURCE: stereo_reg = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				due_frames.push_back(play_step(action_t'(action), address, sample_left,
					sample_right, velocity, mix_left, mix_right));
			end
			if (out_valid && !out_stall) begin
				if (due_frames.size() == 0) begin
					errors++;
					$error("output transaction with nothing pending: left %0d right %0d active %0b",
						out_left, out_right, voice_active);
				end else begin
					want = due_frames.pop_front();
					if (out_left !== want.left) begin
						errors++;
						$error("out_left: expected %0d, got %0d", $signed(want.left), out_left);
					end
					if (out_right !== want.right) begin
						errors++;
						$error("out_right: expected %0d, got %0d", $signed(want.right), out_right);
					end
					if (voice_active !== want.active) begin
						errors++;
						$error("voice_active: expected %0b, got %0b", want.active, voice_active);
					end
				end
			end
			outstanding = due_frames.size();
		end
	end

endmodule

// ----- tb/sv/tb_sample_playback_voice.sv -----
`timescale 1ns / 100ps
module tb_sample_playback_voice;
	import spv_pkg::*;

	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 38;
	localparam int LONG_HOLD     = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            action;
	logic [15:0]           address;
	word_t                 sample_left;
	word_t                 sample_right;
	logic [6:0]            velocity;
	word_t                 mix_left;
	word_t                 mix_right;
	logic                  out_valid;
	logic                  out_stall;
	word_t                 out_left;
	word_t                 out_right;
	logic                  voice_active;
	int                    errors;
	int                    outstanding;

	bit          quiet;
	bit          long_hold;
	bit          loaded [STORE_DEPTH];
	logic [15:0] start_cur;
	logic [16:0] end_cur;

	sample_playback_voice DUT (.*);

	voice_checker u_check (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int gap_len();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t any_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return 16'sh7fff;
		end
		if (r < 10) begin
			return 16'sh8000;
		end
		return word_t'($urandom);
	endfunction

	task automatic send_item(action_t act, logic [15:0] addr, word_t sl, word_t sr,
			logic [6:0] vel, word_t ml, word_t mr);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		address <= addr;
		sample_left <= sl;
		sample_right <= sr;
		velocity <= vel;
		mix_left <= ml;
		mix_right <= mr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_word(logic [15:0] addr, word_t sl, word_t sr);
		loaded[addr] = 1'b1;
		send_item(ACT_LOAD, addr, sl, sr, 7'($urandom), any_word(), any_word());
	endtask

	task automatic trigger_voice(logic [6:0] vel);
		send_item(ACT_TRIGGER, 16'($urandom), any_word(), any_word(), vel, any_word(), any_word());
	endtask

	task automatic stop_voice();
		send_item(ACT_STOP, 16'($urandom), any_word(), any_word(), 7'($urandom), any_word(),
			any_word());
	endtask

	task automatic play_tick(word_t ml, word_t mr);
		send_item(ACT_TICK, 16'($urandom), any_word(), any_word(), 7'($urandom), ml, mr);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
	endtask

	task automatic set_voice(logic [15:0] st, logic [16:0] en, logic [19:0] stp,
			logic [15:0] lv, logic [15:0] pn, logic ss);
		start_cur = st;
		end_cur = (en > {1'b0, st}) ? en : {1'b0, st};
		write_reg(CFG_START_OFFSET, {4'b0, st});
		write_reg(CFG_END_POINT, {3'b0, en});
		write_reg(CFG_PHASE_STEP, stp);
		write_reg(CFG_LEVEL, {4'b0, lv});
		write_reg(CFG_PAN, {4'b0, pn});
		write_reg(CFG_STEREO_SOURCE, {19'b0, ss});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_window();
		for (int a = start_cur; a < end_cur; a++) begin
			if (!loaded[a]) begin
				load_word(16'(a), any_word(), any_word());
			end
		end
	endtask

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		int  len;
		bit  hold;
		out_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				hold = !quiet && ($urandom_range(0, 99) < 30);
				len = 1 + gap_len();
				out_stall <= hold;
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin
		int          r;
		int          len;
		logic [15:0] st;
		logic [16:0] en;
		logic [19:0] stp;
		logic [15:0] a;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_START_OFFSET;
		cfg_wdata = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		address = '0;
		sample_left = '0;
		sample_right = '0;
		velocity = '0;
		mix_left = '0;
		mix_right = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// idle pass-through and an empty play range
		set_voice(16'd0, 17'd0, PHASE_STEP_RESET, LEVEL_RESET, 16'd0, 1'b0);
		play_tick(16'sh7fff, 16'sh8000);
		trigger_voice(7'd127);
		play_tick(16'sh8000, 16'sh7fff);
		stop_voice();
		drain();

		// top of the store, full gain, hard left, playhead carry-out
		set_voice(16'hffff, 17'h10000, 20'hfffff, 16'hffff, 16'h8000, 1'b1);
		load_word(16'hffff, 16'sh8000, 16'sh7fff);
		load_word(16'h0000, 16'sh7fff, 16'sh8000);
		trigger_voice(7'd127);
		play_tick(16'sh8000, 16'sh7fff);
		trigger_voice(7'd0);
		stop_voice();
		drain();

		// end point below start offset, zero level, hard right
		set_voice(16'd100, 17'd50, 20'd0, 16'd0, 16'h7fff, 1'b0);
		trigger_voice(7'd64);
		play_tick(any_word(), any_word());
		play_tick(any_word(), any_word());
		drain();

		// mono source held by a zero step, retrigger while playing
		set_voice(16'd0, 17'd1, 20'd0, 16'hffff, 16'h7fff, 1'b0);
		trigger_voice(7'd127);
		play_tick(16'sh0000, 16'sh7fff);
		play_tick(any_word(), any_word());
		trigger_voice(7'd1);
		play_tick(any_word(), any_word());
		stop_voice();
		play_tick(any_word(), any_word());
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			quiet = (p % 4 == 3);
			st = 16'($urandom);
			r = $urandom_range(0, 99);
			len = (r < 5) ? 0 : $urandom_range(1, 24);
			if (r >= 5 && r < 15) begin
				en = 17'($urandom_range(0, st));
			end else if ({1'b0, st} + 17'(len) > 17'h10000) begin
				en = 17'h10000;
			end else begin
				en = {1'b0, st} + 17'(len);
			end
			r = $urandom_range(0, 99);
			if (r < 40) begin
				stp = PHASE_STEP_RESET;
			end else if (r < 70) begin
				stp = 20'($urandom);
			end else begin
				stp = 20'($urandom_range(4096, 1 << 17));
			end
			set_voice(st, en, stp, 16'($urandom), 16'($urandom), 1'($urandom));
			fill_window();
			if (p == 2) begin
				long_hold = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == PHASE_ITEMS / 2) begin
					drain();
				end
				r = $urandom_range(0, 99);
				if (r < 12) begin
					trigger_voice(7'($urandom));
				end else if (r < 17) begin
					stop_voice();
				end else if (r < 32) begin
					if (end_cur > {1'b0, start_cur} && r < 25) begin
						a = 16'($urandom_range(start_cur, end_cur - 1));
					end else begin
						a = 16'($urandom);
					end
					load_word(a, any_word(), any_word());
				end else begin
					play_tick(any_word(), any_word());
				end
			end
			stop_voice();
			drain();
		end

		quiet = 1'b0;
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spv_pkg.sv
rtl/spv_ctrl.sv
rtl/spv_datapath.sv
rtl/sample_playback_voice.sv
tb/sv/voice_checker.sv
tb/sv/tb_sample_playback_voice.sv
